[hdl/gerq_pkg.sv]
// shared types, codes and reset values of the gamepad edge and repeat qualifier
// no dependencies
`default_nettype none

package gerq_pkg;

  localparam int NUM_BUTTONS_DEF = 32;
  localparam int COUNT_BITS_DEF  = 8;

  localparam int GROUPS     = 4;
  localparam int GROUP_SIZE = 8;
  localparam int OUT_COUNT_BITS = 8;
  localparam int OUT_COUNT_SAT  = 255;

  localparam int CFG_INDEX_BITS = 3;
  localparam int CFG_DATA_BITS  = 16;

  localparam logic [1:0] CMD_DOWN  = 2'd0;
  localparam logic [1:0] CMD_UP    = 2'd1;
  localparam logic [1:0] CMD_FRAME = 2'd2;

  localparam logic [CFG_INDEX_BITS-1:0] CFG_REPEAT_ENABLE   = 3'd0;
  localparam logic [CFG_INDEX_BITS-1:0] CFG_REPEAT_DELAY    = 3'd1;
  localparam logic [CFG_INDEX_BITS-1:0] CFG_REPEAT_INTERVAL = 3'd2;
  localparam logic [CFG_INDEX_BITS-1:0] CFG_DEAD_ZONE       = 3'd3;
  localparam logic [CFG_INDEX_BITS-1:0] CFG_DPAD_BASE       = 3'd4;
  localparam logic [CFG_INDEX_BITS-1:0] CFG_STICK_BASE      = 3'd5;

  localparam logic        RST_REPEAT_ENABLE   = 1'b1;
  localparam logic [15:0] RST_REPEAT_DELAY    = 16'd400;
  localparam logic [15:0] RST_REPEAT_INTERVAL = 16'd80;
  localparam logic [14:0] RST_DEAD_ZONE       = 15'd10000;
  localparam logic [4:0]  RST_DPAD_BASE       = 5'd12;
  localparam logic [4:0]  RST_STICK_BASE      = 5'd16;

  typedef struct packed {
    logic        frame;
    logic        repeat_enable;
    logic [15:0] repeat_delay_ms;
    logic [15:0] repeat_interval_ms;
    logic [31:0] now_ms;
  } lane_ctrl_t;

  typedef struct packed {
    logic busy;
    logic done;
  } out_status_t;

endpackage

`default_nettype wire

[hdl/gerq_lane.sv]
// one button lane: press count, repeat state and hold/fire timestamps
// depends on gerq_pkg
`default_nettype none

module gerq_lane #(
  parameter int COUNT_BITS = gerq_pkg::COUNT_BITS_DEF
) (
  input  logic                clk,
  input  logic                rst,
  input  gerq_pkg::lane_ctrl_t ctrl,
  input  logic                down,
  input  logic                held,
  input  logic                rise,
  input  logic                pressed,
  output logic                fire,
  output logic [gerq_pkg::OUT_COUNT_BITS-1:0] snap_count
);
  import gerq_pkg::*;

  localparam int CW = (COUNT_BITS > OUT_COUNT_BITS) ? COUNT_BITS : OUT_COUNT_BITS;

  logic [COUNT_BITS-1:0] count;
  logic                  active;
  logic [31:0]           hold_start;
  logic [31:0]           last_fire;

  logic [31:0]           hs_eff;
  logic [31:0]           lf_eff;
  logic                  rep_ok;
  logic                  rep_fire;
  logic [COUNT_BITS-1:0] cnt_eff;
  logic [CW-1:0]         cnt_wide;

  always_comb begin
    hs_eff   = active ? hold_start : ctrl.now_ms;
    lf_eff   = active ? last_fire : ctrl.now_ms;
    rep_ok   = held && ctrl.repeat_enable &&
               ((ctrl.now_ms - hs_eff) >= 32'(ctrl.repeat_delay_ms)) &&
               ((ctrl.now_ms - lf_eff) >= 32'(ctrl.repeat_interval_ms));
    rep_fire = !pressed && rep_ok;
    fire     = pressed || rep_ok;
    cnt_eff  = (rise && count == '0) ? COUNT_BITS'(1) : count;
    cnt_wide = CW'(cnt_eff);
    snap_count = (cnt_wide > CW'(OUT_COUNT_SAT)) ? OUT_COUNT_BITS'(OUT_COUNT_SAT)
                                                 : cnt_wide[OUT_COUNT_BITS-1:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count  <= '0;
      active <= 1'b0;
    end else if (ctrl.frame) begin
      count  <= '0;
      active <= held;
    end else if (down && count != '1) begin
      count <= count + COUNT_BITS'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.frame && held && !active) begin
      hold_start <= ctrl.now_ms;
      last_fire  <= ctrl.now_ms;
    end
    if (ctrl.frame && rep_fire) begin
      last_fire <= ctrl.now_ms;
    end
  end

endmodule

`default_nettype wire

[hdl/gerq_merge.sv]
// merge stage: captures the lane results of a frame and sends four result requests
// depends on gerq_pkg
`default_nettype none

module gerq_merge #(
  parameter int NUM_BUTTONS = gerq_pkg::NUM_BUTTONS_DEF
) (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    load,
  input  logic [NUM_BUTTONS-1:0]  held_in,
  input  logic [NUM_BUTTONS-1:0]  pressed_in,
  input  logic [NUM_BUTTONS-1:0]  released_in,
  input  logic [NUM_BUTTONS-1:0]  fire_in,
  input  logic [gerq_pkg::OUT_COUNT_BITS-1:0] snap [NUM_BUTTONS],
  output gerq_pkg::out_status_t   status,
  output logic                    result_valid,
  input  logic                    result_stall,
  output logic [31:0]             held_buttons,
  output logic [31:0]             pressed_mask,
  output logic [31:0]             released_mask,
  output logic [31:0]             repeat_mask,
  output logic [1:0]              count_group,
  output logic [63:0]             press_counts,
  output logic                    last
);
  import gerq_pkg::*;

  localparam int WORD_BITS = GROUP_SIZE * OUT_COUNT_BITS;
  localparam logic [1:0] LAST_GROUP = 2'(GROUPS - 1);

  logic                 busy;
  logic [1:0]           grp;
  logic [WORD_BITS-1:0] words [GROUPS];
  logic [WORD_BITS-1:0] load_words [GROUPS];
  logic                 advance;

  for (genvar g = 0; g < GROUPS; g++) begin : g_pack
    for (genvar j = 0; j < GROUP_SIZE; j++) begin : g_byte
      if (g * GROUP_SIZE + j < NUM_BUTTONS) begin : g_used
        assign load_words[g][j*OUT_COUNT_BITS +: OUT_COUNT_BITS] = snap[g * GROUP_SIZE + j];
      end else begin : g_unused
        assign load_words[g][j*OUT_COUNT_BITS +: OUT_COUNT_BITS] = '0;
      end
    end
  end

  assign advance      = busy && !result_stall;
  assign last         = (grp == LAST_GROUP);
  assign status.busy  = busy;
  assign status.done  = advance && last;
  assign result_valid = busy;
  assign count_group  = grp;
  assign press_counts = words[0];

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      grp  <= '0;
    end else if (load) begin
      busy <= 1'b1;
      grp  <= '0;
    end else if (advance) begin
      if (last) begin
        busy <= 1'b0;
      end else begin
        grp <= grp + 2'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      held_buttons  <= 32'(held_in);
      pressed_mask  <= 32'(pressed_in);
      released_mask <= 32'(released_in);
      repeat_mask   <= 32'(fire_in);
      for (int g = 0; g < GROUPS; g++) begin
        words[g] <= load_words[g];
      end
    end else if (advance) begin
      for (int g = 0; g < GROUPS - 1; g++) begin
        words[g] <= words[g + 1];
      end
      words[GROUPS-1] <= '0;
    end
  end

  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    load |-> (!busy || (last && !result_stall)))
    else $error("frame results overwritten before delivery");

  a_fire_covers_press: assert property (@(posedge clk) disable iff (rst)
    busy |-> ((pressed_mask & ~repeat_mask) == 32'd0))
    else $error("pressed button missing from repeat mask");

  a_group_step: assert property (@(posedge clk) disable iff (rst)
    (advance && !last && !load) |=> (busy && grp == 2'($past(grp) + 2'd1)))
    else $error("result group did not step");

  a_end_on_last: assert property (@(posedge clk) disable iff (rst)
    $fell(busy) |-> $past(last && !result_stall))
    else $error("frame ended before last result");

endmodule

`default_nettype wire

[hdl/gamepad_edge_repeat_qualifier_unit.sv]
// Gamepad edge and auto-repeat qualifier. Down and up event requests are taken one per
// cycle and update the per-button press counters and event masks. A frame poll passes
// combinationally through the stick dead zone, D-pad merge and the per-button lanes, then
// the merge stage registers its results and sends four result requests (one per group of
// eight counts, last on the fourth), each held while result_stall is high. A new frame
// poll is accepted no earlier than the cycle its predecessor's last result is taken;
// events keep flowing meanwhile. No clearing pass after reset.
// depends on gerq_pkg, gerq_lane, gerq_merge
`default_nettype none

module gamepad_edge_repeat_qualifier_unit #(
  parameter int NUM_BUTTONS = gerq_pkg::NUM_BUTTONS_DEF,
  parameter int COUNT_BITS  = gerq_pkg::COUNT_BITS_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [gerq_pkg::CFG_INDEX_BITS-1:0] cfg_index,
  input  logic [gerq_pkg::CFG_DATA_BITS-1:0]  cfg_data,
  input  logic        item_valid,
  output logic        item_stall,
  input  logic [1:0]  cmd,
  input  logic [4:0]  button_index,
  input  logic [31:0] raw_buttons,
  input  logic signed [15:0] stick_x,
  input  logic signed [15:0] stick_y,
  input  logic [31:0] now_ms,
  output logic        result_valid,
  input  logic        result_stall,
  output logic [31:0] held_buttons,
  output logic [31:0] pressed_mask,
  output logic [31:0] released_mask,
  output logic [31:0] repeat_mask,
  output logic [1:0]  count_group,
  output logic [63:0] press_counts,
  output logic        last
);
  import gerq_pkg::*;

  logic        repeat_enable;
  logic [15:0] repeat_delay_ms;
  logic [15:0] repeat_interval_ms;
  logic [14:0] dead_zone;
  logic [4:0]  dpad_base;
  logic [4:0]  stick_base;

  logic [NUM_BUTTONS-1:0] prev_held;
  logic [NUM_BUTTONS-1:0] event_down_acc;
  logic [NUM_BUTTONS-1:0] event_up_acc;

  out_status_t            status;
  lane_ctrl_t             ctrl;
  logic                   accept;
  logic                   frame;
  logic                   idx_ok;
  logic                   down_hit;
  logic                   up_hit;
  logic [31:0]            held32;
  logic [3:0]             dir;
  logic signed [16:0]     sx;
  logic signed [16:0]     sy;
  logic signed [16:0]     dz;
  logic [NUM_BUTTONS-1:0] held;
  logic [NUM_BUTTONS-1:0] rise;
  logic [NUM_BUTTONS-1:0] pressed;
  logic [NUM_BUTTONS-1:0] released;
  logic [NUM_BUTTONS-1:0] fire;
  logic [OUT_COUNT_BITS-1:0] snap [NUM_BUTTONS];

  function automatic logic [31:0] bit_at(input logic [5:0] pos);
    logic [31:0] r;
    r = '0;
    if (pos < 6'(NUM_BUTTONS)) begin
      r = 32'd1 << pos;
    end
    return r;
  endfunction

  assign cfg_ready  = 1'b1;
  assign item_stall = (cmd == CMD_FRAME) && status.busy && !status.done;
  assign accept     = item_valid && !item_stall;
  assign frame      = accept && (cmd == CMD_FRAME);
  assign idx_ok     = {1'b0, button_index} < 6'(NUM_BUTTONS);
  assign down_hit   = accept && (cmd == CMD_DOWN) && idx_ok;
  assign up_hit     = accept && (cmd == CMD_UP) && idx_ok;

  always_comb begin
    sx     = 17'(stick_x);
    sy     = 17'(stick_y);
    dz     = $signed({2'b00, dead_zone});
    dir[0] = sy < -dz;
    dir[1] = sy > dz;
    dir[2] = sx < -dz;
    dir[3] = sx > dz;
    held32 = raw_buttons;
    for (int k = 0; k < 4; k++) begin
      if (dir[k]) begin
        held32 = held32 | bit_at({1'b0, stick_base} + 6'(k));
      end
    end
    for (int k = 0; k < 4; k++) begin
      if ((held32 & bit_at({1'b0, stick_base} + 6'(k))) != 32'd0) begin
        held32 = held32 | bit_at({1'b0, dpad_base} + 6'(k));
      end
    end
    held     = held32[NUM_BUTTONS-1:0];
    rise     = held & ~prev_held;
    pressed  = rise | event_down_acc;
    released = (prev_held & ~held) | event_up_acc;
  end

  assign ctrl.frame              = frame;
  assign ctrl.repeat_enable      = repeat_enable;
  assign ctrl.repeat_delay_ms    = repeat_delay_ms;
  assign ctrl.repeat_interval_ms = repeat_interval_ms;
  assign ctrl.now_ms             = now_ms;

  always_ff @(posedge clk) begin
    if (rst) begin
      repeat_enable      <= RST_REPEAT_ENABLE;
      repeat_delay_ms    <= RST_REPEAT_DELAY;
      repeat_interval_ms <= RST_REPEAT_INTERVAL;
      dead_zone          <= RST_DEAD_ZONE;
      dpad_base          <= RST_DPAD_BASE;
      stick_base         <= RST_STICK_BASE;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        CFG_REPEAT_ENABLE:   repeat_enable      <= cfg_data[0];
        CFG_REPEAT_DELAY:    repeat_delay_ms    <= cfg_data;
        CFG_REPEAT_INTERVAL: repeat_interval_ms <= cfg_data;
        CFG_DEAD_ZONE:       dead_zone          <= cfg_data[14:0];
        CFG_DPAD_BASE:       dpad_base          <= cfg_data[4:0];
        CFG_STICK_BASE:      stick_base         <= cfg_data[4:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      prev_held      <= '0;
      event_down_acc <= '0;
      event_up_acc   <= '0;
    end else if (frame) begin
      prev_held      <= held;
      event_down_acc <= '0;
      event_up_acc   <= '0;
    end else if (down_hit) begin
      event_down_acc <= event_down_acc | (NUM_BUTTONS'(1) << button_index);
    end else if (up_hit) begin
      event_up_acc <= event_up_acc | (NUM_BUTTONS'(1) << button_index);
    end
  end

  for (genvar i = 0; i < NUM_BUTTONS; i++) begin : g_lane
    gerq_lane #(
      .COUNT_BITS(COUNT_BITS)
    ) u_lane (
      .clk       (clk),
      .rst       (rst),
      .ctrl      (ctrl),
      .down      (down_hit && (button_index == 5'(i))),
      .held      (held[i]),
      .rise      (rise[i]),
      .pressed   (pressed[i]),
      .fire      (fire[i]),
      .snap_count(snap[i])
    );
  end

  gerq_merge #(
    .NUM_BUTTONS(NUM_BUTTONS)
  ) u_merge (
    .clk          (clk),
    .rst          (rst),
    .load         (frame),
    .held_in      (held),
    .pressed_in   (pressed),
    .released_in  (released),
    .fire_in      (fire),
    .snap         (snap),
    .status       (status),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .held_buttons (held_buttons),
    .pressed_mask (pressed_mask),
    .released_mask(released_mask),
    .repeat_mask  (repeat_mask),
    .count_group  (count_group),
    .press_counts (press_counts),
    .last         (last)
  );

  a_accs_clear: assert property (@(posedge clk) disable iff (rst)
    frame |=> (event_down_acc == '0 && event_up_acc == '0))
    else $error("event masks not cleared by frame");

  a_frame_loads: assert property (@(posedge clk) disable iff (rst)
    frame |=> (result_valid && count_group == 2'd0))
    else $error("frame did not start results");

  a_event_no_result: assert property (@(posedge clk) disable iff (rst)
    (!status.busy && !frame) |=> !result_valid)
    else $error("result without frame");

endmodule

`default_nettype wire

[sim/gerq_checker.sv]
// gamepad edge and repeat qualifier checker: watches the register, item and result channels,
// predicts the four results of each frame poll and compares them field by field
// depends on gerq_pkg
module gerq_checker (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_valid,
  input  logic        cfg_ready,
  input  logic [gerq_pkg::CFG_INDEX_BITS-1:0] cfg_index,
  input  logic [gerq_pkg::CFG_DATA_BITS-1:0]  cfg_data,
  input  logic        item_valid,
  input  logic        item_stall,
  input  logic [1:0]  cmd,
  input  logic [4:0]  button_index,
  input  logic [31:0] raw_buttons,
  input  logic signed [15:0] stick_x,
  input  logic signed [15:0] stick_y,
  input  logic [31:0] now_ms,
  input  logic        result_valid,
  input  logic        result_stall,
  input  logic [31:0] held_buttons,
  input  logic [31:0] pressed_mask,
  input  logic [31:0] released_mask,
  input  logic [31:0] repeat_mask,
  input  logic [1:0]  count_group,
  input  logic [63:0] press_counts,
  input  logic        last,
  output int          fail_count,
  output int          expect_left,
  output int          results_seen,
  output int          frames_seen
);
  timeunit 1ns;
  timeprecision 1ps;
  import gerq_pkg::*;

  localparam int NB = NUM_BUTTONS_DEF;

  typedef struct packed {
    logic [31:0] held;
    logic [31:0] pressed;
    logic [31:0] released;
    logic [31:0] fire;
    logic [1:0]  group;
    logic [63:0] counts;
    logic        last_flag;
  } qual_result_t;

  qual_result_t frame_results_q[$];

  logic        rep_en;
  logic [15:0] rep_delay;
  logic [15:0] rep_interval;
  logic [14:0] dz_level;
  logic [4:0]  dpad_pos;
  logic [4:0]  stick_pos;

  logic [31:0] prev_held;
  logic [31:0] down_acc;
  logic [31:0] up_acc;
  logic [7:0]  press_cnt [NB];
  logic        hold_active [NB];
  logic [31:0] hold_since [NB];
  logic [31:0] fired_at [NB];

  int fails = 0;
  int n_results = 0;
  int n_frames = 0;

  assign fail_count   = fails;
  assign results_seen = n_results;
  assign frames_seen  = n_frames;

  task automatic report(input string field, input logic [63:0] got, input logic [63:0] want);
    $display("mismatch %s: got %h want %h at %0t", field, got, want, $realtime);
    fails++;
  endtask

  function automatic logic [31:0] pad_bit(input int pos);
    if (pos < 0 || pos >= NB) return '0;
    return 32'd1 << pos;
  endfunction

  task automatic clear_pad();
    rep_en       = RST_REPEAT_ENABLE;
    rep_delay    = RST_REPEAT_DELAY;
    rep_interval = RST_REPEAT_INTERVAL;
    dz_level     = RST_DEAD_ZONE;
    dpad_pos     = RST_DPAD_BASE;
    stick_pos    = RST_STICK_BASE;
    prev_held = '0;
    down_acc  = '0;
    up_acc    = '0;
    for (int i = 0; i < NB; i++) begin
      press_cnt[i]   = '0;
      hold_active[i] = 1'b0;
      hold_since[i]  = '0;
      fired_at[i]    = '0;
    end
    frame_results_q.delete();
  endtask

  task automatic write_register(input logic [CFG_INDEX_BITS-1:0] idx,
                                input logic [CFG_DATA_BITS-1:0] data);
    case (idx)
      CFG_REPEAT_ENABLE:   rep_en = data[0];
      CFG_REPEAT_DELAY:    rep_delay = data;
      CFG_REPEAT_INTERVAL: rep_interval = data;
      CFG_DEAD_ZONE:       dz_level = data[14:0];
      CFG_DPAD_BASE:       dpad_pos = data[4:0];
      CFG_STICK_BASE:      stick_pos = data[4:0];
      default: ;
    endcase
  endtask

  task automatic log_button_event(input logic [1:0] c, input logic [4:0] idx);
    if (int'(idx) >= NB) return;
    if (c == CMD_DOWN) begin
      down_acc |= pad_bit(int'(idx));
      if (press_cnt[idx] != 8'hFF) press_cnt[idx] = press_cnt[idx] + 8'd1;
    end else begin
      up_acc |= pad_bit(int'(idx));
    end
  endtask

  task automatic qualify_frame(input logic [31:0] raw, input logic signed [15:0] sx,
                               input logic signed [15:0] sy, input logic [31:0] now);
    logic [31:0] held, rise, pressed, released, fire, sbit, since_hold, since_fire;
    logic [63:0] pk;
    int dz, sxi, syi;
    qual_result_t r;
    held = raw;
    dz = int'(dz_level);
    sxi = sx;
    syi = sy;
    if (syi < -dz) held |= pad_bit(int'(stick_pos) + 0);
    if (syi > dz)  held |= pad_bit(int'(stick_pos) + 1);
    if (sxi < -dz) held |= pad_bit(int'(stick_pos) + 2);
    if (sxi > dz)  held |= pad_bit(int'(stick_pos) + 3);
    for (int k = 0; k < 4; k++) begin
      sbit = pad_bit(int'(stick_pos) + k);
      if (sbit != 0 && (held & sbit) != 0) held |= pad_bit(int'(dpad_pos) + k);
    end
    rise     = held & ~prev_held;
    pressed  = rise | down_acc;
    released = (prev_held & ~held) | up_acc;
    fire     = '0;
    for (int i = 0; i < NB; i++) begin
      if (rise[i] && press_cnt[i] == 0) press_cnt[i] = 8'd1;
      if (held[i]) begin
        if (!hold_active[i]) begin
          hold_active[i] = 1'b1;
          hold_since[i]  = now;
          fired_at[i]    = now;
        end
      end else begin
        hold_active[i] = 1'b0;
      end
      if (pressed[i]) begin
        fire[i] = 1'b1;
      end else if (held[i] && rep_en && hold_active[i]) begin
        since_hold = now - hold_since[i];
        since_fire = now - fired_at[i];
        if (since_hold >= {16'd0, rep_delay} && since_fire >= {16'd0, rep_interval}) begin
          fired_at[i] = now;
          fire[i] = 1'b1;
        end
      end
    end
    for (int g = 0; g < GROUPS; g++) begin
      pk = '0;
      for (int j = 0; j < GROUP_SIZE; j++)
        if (g * GROUP_SIZE + j < NB) pk[8*j +: 8] = press_cnt[g * GROUP_SIZE + j];
      r.held      = held;
      r.pressed   = pressed;
      r.released  = released;
      r.fire      = fire;
      r.group     = 2'(g);
      r.counts    = pk;
      r.last_flag = (g == GROUPS - 1);
      frame_results_q.push_back(r);
    end
    prev_held = held;
    down_acc  = '0;
    up_acc    = '0;
    for (int i = 0; i < NB; i++) press_cnt[i] = '0;
  endtask

  always @(posedge clk) begin
    qual_result_t want;
    if (rst) begin
      clear_pad();
      expect_left <= 0;
    end else begin
      if (cfg_valid && cfg_ready) write_register(cfg_index, cfg_data);
      if (item_valid && !item_stall) begin
        case (cmd)
          CMD_DOWN, CMD_UP: log_button_event(cmd, button_index);
          CMD_FRAME: begin
            n_frames++;
            qualify_frame(raw_buttons, stick_x, stick_y, now_ms);
          end
          default: ;
        endcase
      end
      if (result_valid && !result_stall) begin
        n_results++;
        if (frame_results_q.size() == 0) begin
          report("result with no request waiting", press_counts, '0);
        end else begin
          want = frame_results_q.pop_front();
          if (held_buttons !== want.held) report("held_buttons", held_buttons, want.held);
          if (pressed_mask !== want.pressed) report("pressed_mask", pressed_mask, want.pressed);
          if (released_mask !== want.released)
            report("released_mask", released_mask, want.released);
          if (repeat_mask !== want.fire) report("repeat_mask", repeat_mask, want.fire);
          if (count_group !== want.group) report("count_group", count_group, want.group);
          if (press_counts !== want.counts) report("press_counts", press_counts, want.counts);
          if (last !== want.last_flag) report("last", last, want.last_flag);
        end
      end
      expect_left <= frame_results_q.size();
    end
  end

endmodule

[sim/tb_top.sv]
// testbench top for gamepad_edge_repeat_qualifier_unit: drives register writes, button
// events and frame polls with random idling, and gives the verdict from gerq_checker
// depends on gerq_pkg, gerq_checker and the unit under test
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;
  import gerq_pkg::*;

  localparam logic [1:0] CMD_UNUSED = 2'd3;
  localparam logic [CFG_INDEX_BITS-1:0] CFG_UNUSED_INDEX = 3'd7;
  localparam int SETTLE_CYCLES = 10;
  localparam int LIMIT_CYCLES = 400000;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [CFG_INDEX_BITS-1:0] cfg_index = '0;
  logic [CFG_DATA_BITS-1:0]  cfg_data = '0;
  logic        item_valid = 1'b0;
  logic        item_stall;
  logic [1:0]  cmd = CMD_DOWN;
  logic [4:0]  button_index = '0;
  logic [31:0] raw_buttons = '0;
  logic signed [15:0] stick_x = '0;
  logic signed [15:0] stick_y = '0;
  logic [31:0] now_ms = '0;
  logic        result_valid;
  logic        result_stall = 1'b0;
  logic [31:0] held_buttons, pressed_mask, released_mask, repeat_mask;
  logic [1:0]  count_group;
  logic [63:0] press_counts;
  logic        last;

  int fail_count, expect_left, results_seen, frames_seen;
  int cycle_count = 0;
  int items_sent = 0;
  int settings_used = 1;
  bit idle_on = 1'b1;
  int stim_dz = int'(RST_DEAD_ZONE);
  logic [31:0] pad_held = '0;
  logic [31:0] pad_time = '0;

  gamepad_edge_repeat_qualifier_unit uut (
    .clk(clk), .rst(rst),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .item_valid(item_valid), .item_stall(item_stall), .cmd(cmd), .button_index(button_index),
    .raw_buttons(raw_buttons), .stick_x(stick_x), .stick_y(stick_y), .now_ms(now_ms),
    .result_valid(result_valid), .result_stall(result_stall), .held_buttons(held_buttons),
    .pressed_mask(pressed_mask), .released_mask(released_mask), .repeat_mask(repeat_mask),
    .count_group(count_group), .press_counts(press_counts), .last(last)
  );

  gerq_checker chk (
    .clk(clk), .rst(rst),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .item_valid(item_valid), .item_stall(item_stall), .cmd(cmd), .button_index(button_index),
    .raw_buttons(raw_buttons), .stick_x(stick_x), .stick_y(stick_y), .now_ms(now_ms),
    .result_valid(result_valid), .result_stall(result_stall), .held_buttons(held_buttons),
    .pressed_mask(pressed_mask), .released_mask(released_mask), .repeat_mask(repeat_mask),
    .count_group(count_group), .press_counts(press_counts), .last(last),
    .fail_count(fail_count), .expect_left(expect_left), .results_seen(results_seen),
    .frames_seen(frames_seen)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) cycle_count <= cycle_count + 1;

  initial begin
    wait (cycle_count >= LIMIT_CYCLES);
    $display("timeout after %0d cycles, %0d results still due", cycle_count, expect_left);
    $display("[FAIL] regression broken");
    $finish;
  end

  // result side backpressure
  initial begin
    forever begin
      if (idle_on && $urandom_range(0, 2) == 0) begin
        result_stall <= 1'b1;
        repeat ($urandom_range(1, 19)) @(posedge clk);
      end
      result_stall <= 1'b0;
      repeat ($urandom_range(1, 12)) @(posedge clk);
    end
  end

  task automatic send_item(input logic [1:0] c, input logic [4:0] idx, input logic [31:0] raw,
                           input logic [15:0] sx, input logic [15:0] sy, input logic [31:0] t);
    if (idle_on && $urandom_range(0, 3) == 0) begin
      item_valid <= 1'b0;
      repeat ($urandom_range(1, 19)) @(posedge clk);
    end
    item_valid   <= 1'b1;
    cmd          <= c;
    button_index <= idx;
    raw_buttons  <= raw;
    stick_x      <= sx;
    stick_y      <= sy;
    now_ms       <= t;
    do @(posedge clk); while (item_stall);
    items_sent++;
  endtask

  task automatic send_frame(input logic [31:0] raw, input logic [15:0] sx,
                            input logic [15:0] sy, input logic [31:0] t);
    send_item(CMD_FRAME, 5'($urandom), raw, sx, sy, t);
  endtask

  task automatic send_event(input logic [1:0] c, input logic [4:0] idx);
    send_item(c, idx, $urandom, 16'($urandom), 16'($urandom), $urandom);
  endtask

  task automatic drain();
    item_valid <= 1'b0;
    @(posedge clk);
    while (expect_left != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic cfg_write(input logic [CFG_INDEX_BITS-1:0] idx,
                           input logic [CFG_DATA_BITS-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk); while (!cfg_ready);
  endtask

  task automatic set_config(input logic [15:0] en, input logic [15:0] delay,
                            input logic [15:0] interval, input logic [15:0] dz,
                            input logic [15:0] dpad, input logic [15:0] stick);
    drain();
    cfg_write(CFG_REPEAT_ENABLE, en);
    cfg_write(CFG_REPEAT_DELAY, delay);
    cfg_write(CFG_REPEAT_INTERVAL, interval);
    cfg_write(CFG_DEAD_ZONE, dz);
    cfg_write(CFG_DPAD_BASE, dpad);
    cfg_write(CFG_STICK_BASE, stick);
    cfg_valid <= 1'b0;
    stim_dz = int'(dz[14:0]);
    settings_used++;
  endtask

  function automatic logic [15:0] pick_axis();
    case ($urandom_range(0, 7))
      0: return 16'd0;
      1: return 16'(stim_dz);
      2: return 16'(-stim_dz);
      3: return 16'(stim_dz + 1);
      4: return 16'(-stim_dz - 1);
      5: return 16'h7FFF;
      6: return 16'h8000;
      default: return 16'($urandom);
    endcase
  endfunction

  // mostly sustained holds with advancing time, plus events and unused commands
  task automatic random_traffic(input int n);
    int sel;
    logic [15:0] sx, sy;
    for (int k = 0; k < n; k++) begin
      sel = $urandom_range(0, 99);
      if (sel < 42) begin
        case ($urandom_range(0, 9))
          0: pad_held = $urandom;
          1: pad_held = '0;
          2, 3: pad_held = pad_held ^ (32'd1 << $urandom_range(0, 31));
          default: ;
        endcase
        if ($urandom_range(0, 24) == 0) pad_time = $urandom;
        else pad_time = pad_time + 32'($urandom_range(0, 160));
        sx = ($urandom_range(0, 1) != 0) ? pick_axis() : 16'd0;
        sy = ($urandom_range(0, 1) != 0) ? pick_axis() : 16'd0;
        send_frame(pad_held, sx, sy, pad_time);
      end else if (sel < 90) begin
        send_event(($urandom_range(0, 2) != 0) ? CMD_DOWN : CMD_UP, 5'($urandom));
      end else begin
        send_item(CMD_UNUSED, 5'($urandom), $urandom, 16'($urandom), 16'($urandom), $urandom);
      end
    end
  endtask

  // drive one count past saturation
  task automatic hammer_button();
    logic [4:0] idx;
    idx = 5'($urandom);
    for (int k = 0; k < 256; k++) send_event(CMD_DOWN, idx);
    pad_time = pad_time + 32'd20;
    send_frame(pad_held, 16'd0, 16'd0, pad_time);
  endtask

  initial begin
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    // directed part at reset settings
    send_frame(32'h0, 16'd0, 16'd0, 32'd0);
    send_event(CMD_DOWN, 5'd0);
    send_event(CMD_DOWN, 5'd31);
    send_event(CMD_UP, 5'd5);
    send_event(CMD_UP, 5'd31);
    send_frame(32'hFFFF_FFFF, 16'h7FFF, 16'h8000, 32'd100);
    send_frame(32'hFFFF_FFFF, 16'h8000, 16'h7FFF, 32'd500);
    send_frame(32'hFFFF_FFFF, 16'h8000, 16'h7FFF, 32'd540);
    send_frame(32'hFFFF_FFFF, 16'h8000, 16'h7FFF, 32'd580);
    send_item(CMD_UNUSED, 5'($urandom), $urandom, 16'($urandom), 16'($urandom), $urandom);
    send_frame(32'h0, 16'd10000, -16'sd10000, 32'd600);
    send_frame(32'h0, 16'd10001, -16'sd10001, 32'd610);
    send_frame(32'h0, -16'sd10001, 16'd10001, 32'd620);
    send_frame(32'h1, 16'd0, 16'd0, 32'hFFFF_FF00);
    send_frame(32'h1, 16'd0, 16'd0, 32'h0000_0100);
    send_event(CMD_DOWN, 5'd7);
    send_event(CMD_DOWN, 5'd7);
    send_frame(32'h81, 16'd0, 16'd0, 32'h0000_0110);
    send_frame(32'h181, 16'd0, 16'd0, 32'h0000_0120);
    send_item(CMD_UNUSED, 5'($urandom), $urandom, 16'($urandom), 16'($urandom), $urandom);
    pad_held = 32'h181;
    pad_time = 32'h0000_0200;

    drain();
    cfg_write(CFG_UNUSED_INDEX, 16'($urandom));
    cfg_valid <= 1'b0;

    set_config(16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 16'd4);
    random_traffic(18);

    // wide values keep only their low bits
    set_config(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'd28);
    random_traffic(18);

    set_config(16'd1, 16'd0, 16'd0, 16'd3000, 16'd28, 16'd0);
    hammer_button();
    random_traffic(20);

    set_config(16'($urandom), 16'($urandom_range(0, 500)), 16'($urandom_range(0, 200)),
               16'($urandom_range(0, 32767)), 16'($urandom_range(0, 31)),
               16'($urandom_range(0, 31)));
    random_traffic(18);

    drain();
    idle_on = 1'b0;
    set_config({15'd0, RST_REPEAT_ENABLE}, RST_REPEAT_DELAY, RST_REPEAT_INTERVAL,
               {1'b0, RST_DEAD_ZONE}, {11'd0, RST_DPAD_BASE}, {11'd0, RST_STICK_BASE});
    random_traffic(19);

    drain();
    $display("sent %0d requests (%0d frame polls) under %0d register settings",
             items_sent, frames_seen, settings_used);
    $display("checked %0d results, %0d mismatches", results_seen, fail_count);
    if (fail_count == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

[filelist.f]
hdl/gerq_pkg.sv
hdl/gerq_lane.sv
hdl/gerq_merge.sv
hdl/gamepad_edge_repeat_qualifier_unit.sv
sim/gerq_checker.sv
sim/tb_top.sv
